/* hw/rtl/bitmap_block_allocator_unit_defines.svh */
// ----------------------------------------------------------------------------
// Bitmap block allocator assertion macros
// Shared property forms for the allocator's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define BBA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define BBA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/bba_pkg.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator package
// Field widths, operation codes and result status codes.
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int DISK_W     = 13;
  localparam int BLK_FIELD_W = 12;
  localparam int STATUS_W   = 2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_t;

endpackage

/* hw/rtl/bba_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bba_find.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator free-bit search
// Finds the lowest clear bit of a bitmap word below a bit limit.
// ----------------------------------------------------------------------------
module bba_find #(
  parameter int WORD_BITS = 64
) (
  input  logic [WORD_BITS-1:0]         word,
  input  logic [$clog2(WORD_BITS):0]   limit,
  output logic                         found,
  output logic [$clog2(WORD_BITS)-1:0] idx,
  output logic [WORD_BITS-1:0]         pick
);

  localparam int LG = $clog2(WORD_BITS);

  logic [WORD_BITS-1:0] in_lim;
  logic [WORD_BITS-1:0] cand;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      in_lim[i] = ((LG + 1)'(i) < limit);
    end
  end

  assign cand  = ~word & in_lim;
  assign pick  = cand & (~cand + WORD_BITS'(1));
  assign found = |cand;

  always_comb begin
    idx = '0;
    for (int j = 0; j < LG; j++) begin
      for (int i = 0; i < WORD_BITS; i++) begin
        if (((i >> j) & 1) == 1) begin
          idx[j] = idx[j] | pick[i];
        end
      end
    end
  end

endmodule

/* hw/rtl/bitmap_block_allocator_unit.sv */
// ----------------------------------------------------------------------------
// Bitmap block allocator, first fit
// A free reads the block's bitmap word and clears its bit if set; a block beyond
// the disk size is answered without a read. An allocate reads one bitmap word
// per cycle from word 0 while the output is not stalled, up to the disk size.
// One transaction is in work at a time; the next one is accepted the cycle
// after a result is loaded, and the output register frees the input.
// After reset a clearing pass that zeroes every bitmap word stalls the input.
// ----------------------------------------------------------------------------
module bitmap_block_allocator_unit #(
  parameter int MAX_BLOCKS = 4096,
  parameter int WORD_BITS  = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bba_pkg::DISK_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_op,
  input  logic [bba_pkg::BLK_FIELD_W-1:0]     in_block,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [bba_pkg::STATUS_W-1:0]        out_status,
  output logic [bba_pkg::BLK_FIELD_W-1:0]     out_block_out
);

  `include "bitmap_block_allocator_unit_defines.svh"

  localparam int NUM_WORDS = MAX_BLOCKS / WORD_BITS;
  localparam int AW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int LG        = $clog2(WORD_BITS);
  localparam int SZ_W      = $clog2(MAX_BLOCKS + 1);
  localparam int CW        = (SZ_W > bba_pkg::DISK_W) ? SZ_W : bba_pkg::DISK_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_SCAN  = 5'b00100,
    S_FRD   = 5'b01000,
    S_FCHK  = 5'b10000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [bba_pkg::DISK_W-1:0]      disk_r;
  logic [AW-1:0]                   clr_r, clr_nxt;
  logic [AW:0]                     rd_w_r, rd_w_nxt;
  logic [AW-1:0]                   chk_w_r, chk_w_nxt;
  logic                            pend_r, pend_nxt;
  logic [bba_pkg::BLK_FIELD_W-1:0] blk_r, blk_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [bba_pkg::STATUS_W-1:0]    out_status_r;
  logic [bba_pkg::BLK_FIELD_W-1:0] out_block_r;

  logic                            load;
  bba_pkg::status_t                ld_status;
  logic [bba_pkg::BLK_FIELD_W-1:0] ld_block;
  logic                            can_out;

  logic [CW-1:0]                   eff;
  logic [CW-1:0]                   base_rd;
  logic [CW-1:0]                   base_chk;
  logic [CW-1:0]                   rem;
  logic [LG:0]                     rem_sat;
  logic                            rd_more;
  logic [CW-1:0]                   blk_e;
  logic [AW-1:0]                   blk_word;
  logic [LG-1:0]                   blk_bit;

  logic                            ram_we;
  logic [AW-1:0]                   ram_waddr;
  logic [WORD_BITS-1:0]            ram_wdata;
  logic                            ram_re;
  logic [AW-1:0]                   ram_raddr;
  logic [WORD_BITS-1:0]            ram_rdata;

  logic                            f_found;
  logic [LG-1:0]                   f_idx;
  logic [WORD_BITS-1:0]            f_pick;

  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NUM_WORDS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  bba_find #(
    .WORD_BITS (WORD_BITS)
  ) u_find (
    .word  (ram_rdata),
    .limit (rem_sat),
    .found (f_found),
    .idx   (f_idx),
    .pick  (f_pick)
  );

  assign eff = (CW'(disk_r) > CW'(MAX_BLOCKS)) ? CW'(MAX_BLOCKS) : CW'(disk_r);

  assign base_rd  = CW'(rd_w_r) << LG;
  assign base_chk = CW'(chk_w_r) << LG;
  assign rd_more  = (base_rd < eff);
  assign rem      = eff - base_chk;
  assign rem_sat  = (rem >= CW'(WORD_BITS)) ? (LG + 1)'(WORD_BITS) : (LG + 1)'(rem);

  assign blk_e    = CW'(blk_r);
  assign blk_word = AW'(blk_e >> LG);
  assign blk_bit  = blk_e[LG-1:0];

  assign can_out  = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    rd_w_nxt  = rd_w_r;
    chk_w_nxt = chk_w_r;
    pend_nxt  = pend_r;
    blk_nxt   = blk_r;
    ram_we    = 1'b0;
    ram_waddr = chk_w_r;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = rd_w_r[AW-1:0];
    load      = 1'b0;
    ld_status = bba_pkg::ST_OK;
    ld_block  = '0;
    case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(NUM_WORDS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          blk_nxt = in_block;
          if (in_op == bba_pkg::OP_ALLOC) begin
            state_nxt = S_SCAN;
            rd_w_nxt  = '0;
            pend_nxt  = 1'b0;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_SCAN: begin
        if (can_out) begin
          if (pend_r && f_found) begin
            ram_we    = 1'b1;
            ram_waddr = chk_w_r;
            ram_wdata = ram_rdata | f_pick;
            load      = 1'b1;
            ld_status = bba_pkg::ST_OK;
            ld_block  = bba_pkg::BLK_FIELD_W'(base_chk | CW'(f_idx));
            pend_nxt  = 1'b0;
            state_nxt = S_IDLE;
          end else if (!pend_r && !rd_more) begin
            load      = 1'b1;
            ld_status = bba_pkg::ST_FULL;
            state_nxt = S_IDLE;
          end else if (rd_more) begin
            ram_re    = 1'b1;
            ram_raddr = rd_w_r[AW-1:0];
            chk_w_nxt = rd_w_r[AW-1:0];
            rd_w_nxt  = rd_w_r + (AW + 1)'(1);
            pend_nxt  = 1'b1;
          end else begin
            pend_nxt  = 1'b0;
          end
        end
      end
      S_FRD: begin
        if (blk_e >= eff) begin
          if (can_out) begin
            load      = 1'b1;
            ld_status = bba_pkg::ST_RANGE;
            state_nxt = S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = blk_word;
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (can_out) begin
          load      = 1'b1;
          state_nxt = S_IDLE;
          if (!ram_rdata[blk_bit]) begin
            ld_status = bba_pkg::ST_ALREADY_FREE;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = blk_word;
            ram_wdata = ram_rdata & ~(WORD_BITS'(1) << blk_bit);
            ld_status = bba_pkg::ST_OK;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rd_w_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      disk_r      <= bba_pkg::DISK_W'(4096);
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rd_w_r      <= rd_w_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        disk_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    chk_w_r <= chk_w_nxt;
    blk_r   <= blk_nxt;
    if (load) begin
      out_status_r <= ld_status;
      out_block_r  <= ld_block;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_block_out = out_block_r;

  `BBA_ASSERT_IMP(a_no_rw_clash, ram_we && ram_re, ram_waddr != ram_raddr, "bitmap read and write collide")
  `BBA_ASSERT_IMP(a_scan_in_range, state_r == S_SCAN && pend_r, base_chk < eff, "scanned word beyond disk size")
  `BBA_ASSERT_IMP(a_block_zero, out_valid_r && out_status_r != bba_pkg::ST_OK, out_block_r == '0, "failed transaction carries a block number")
  `BBA_ASSERT_IMP(a_clear_quiet, state_r == S_CLEAR, !out_valid_r, "result during clearing pass")
  `BBA_ASSERT_NXT(a_load_idle, load, state_r == S_IDLE && out_valid_r, "result loaded without returning to idle")

endmodule
